[rtl/core/cpvpi_pkg.sv]
// ----------------------------------------------------------------------------
// cpvpi_pkg
// Shared types and constants for the lift-axis position/velocity controller:
// operation codes, register indexes, loop limits and the microcode format.
// ----------------------------------------------------------------------------
package cpvpi_pkg;

	// operation codes carried in s_axis_tuser
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_SET_GOAL = 3'd1;
	localparam logic [2:0] OP_JOG      = 3'd2;
	localparam logic [2:0] OP_STOP     = 3'd3;
	localparam logic [2:0] OP_RESET    = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_POS_GAIN     = 3'd0;
	localparam logic [2:0] REG_FF_GAIN      = 3'd1;
	localparam logic [2:0] REG_INNER_GAIN   = 3'd2;
	localparam logic [2:0] REG_LEAD_TICKS   = 3'd3;
	localparam logic [2:0] REG_BOTTOM_LIMIT = 3'd4;
	localparam logic [2:0] REG_TOP_LIMIT    = 3'd5;
	localparam logic [2:0] REG_MAX_STEP     = 3'd6;
	localparam logic [2:0] REG_SETTLE_BAND  = 3'd7;

	// loop limits
	localparam logic signed [31:0] INT_LIMIT      = 32'sd65536;
	localparam logic signed [15:0] MOTOR_LIMIT    = 16'sd32767;
	localparam logic signed [31:0] JOG_STEP       = 32'sd6554;
	localparam logic signed [16:0] JOG_DEADBAND   = 17'sd3277;
	localparam logic signed [32:0] GOAL_ALLOWANCE = 33'sd32768;
	localparam int                 FRAC_BITS      = 16;
	localparam int                 FRAC_SHR       = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
	localparam int                 FRAC_SHL       = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;

	// internal clamps on the wide intermediates
	localparam logic signed [43:0] VERR_LIM = 44'sd1099511627776;    // 2^40
	localparam logic signed [50:0] TSUM_LIM = 51'sd35184372088832;   // 2^45

	// microcode
	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_DISPATCH = 5'd0;
	localparam pc_t PC_CLAMP    = 5'd1;
	localparam pc_t PC_DIFF     = 5'd2;
	localparam pc_t PC_MOVE     = 5'd3;
	localparam pc_t PC_BAND     = 5'd4;
	localparam pc_t PC_PG_LO    = 5'd5;
	localparam pc_t PC_PG_HI    = 5'd6;
	localparam pc_t PC_FF_LO    = 5'd7;
	localparam pc_t PC_FF_HI    = 5'd8;
	localparam pc_t PC_VERR     = 5'd9;
	localparam pc_t PC_INTEG    = 5'd10;
	localparam pc_t PC_LD_LO    = 5'd11;
	localparam pc_t PC_LD_HI    = 5'd12;
	localparam pc_t PC_TSUM     = 5'd13;
	localparam pc_t PC_IN_LO    = 5'd14;
	localparam pc_t PC_IN_HI    = 5'd15;
	localparam pc_t PC_DRIVE    = 5'd16;
	localparam pc_t PC_MISC     = 5'd17;
	localparam pc_t PC_OUT      = 5'd18;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_MISC,
		UOP_CLAMP_GOAL,
		UOP_DIFF,
		UOP_MOVE_SP,
		UOP_BAND,
		UOP_MAC_LO,
		UOP_MAC_HI,
		UOP_VERR,
		UOP_INTEG,
		UOP_TSUM,
		UOP_DRIVE,
		UOP_OUT
	} uop_t;

	typedef enum logic [1:0] {GAIN_POS, GAIN_FF, GAIN_INNER, GAIN_LEAD} gain_t;

	typedef enum logic [1:0] {COND_NONE, COND_ALWAYS, COND_NOT_TICK, COND_BAND} cond_t;

	typedef struct packed {
		uop_t  uop;
		gain_t gain;
		logic  ld_dsp;    // MAC_HI also loads setpoint change into operand
		cond_t cond;
		pc_t   target;
		logic  wait_out;  // hold until output register is free
		logic  done;
	} ucw_t;

	typedef struct packed {
		logic  fire;
		uop_t  uop;
		gain_t gain;
		logic  ld_dsp;
	} dp_ctl_t;

	typedef struct packed {
		logic is_tick;
		logic band_hit;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/cascaded_position_velocity_pi_top.sv]
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pi_top
// Lift-axis position controller: goal/jog handling, setpoint ramp, P+FF
// position loop feeding a clamped velocity PI, saturated motor command.
// ----------------------------------------------------------------------------
// Sequence: a tick beat runs dispatch, goal clamp, differences, setpoint move,
//   band check, P and FF products (skipped inside the settle band), velocity
//   error, integrator, lead product, sum, inner product, drive and output;
//   set goal, jog, stop, reset and unknown codes run dispatch, misc, output.
// A new beat is taken only when the last program ends; its length is set
//   mostly by the eight passes through the one MAC. A result still waiting on
//   m_axis_tready holds the program at its last step.
// Reset (arst_n low, async): gains 1.0, limits 0..64.0, max step 1.0,
//   settle band 0.5; all loop state zero; no result pending.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_pi_top (
	input  logic        clk,
	input  logic        arst_n,

	// input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,   // measured_position[31:0], goal_height[63:32],
	                                    // jog_command[79:64]
	input  logic [2:0]  s_axis_tuser,   // operation[2:0]

	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // motor_command[15:0], in_band[16],
	                                    // setpoint_at_goal[17], at_floor[18],
	                                    // at_top[19], zero[23:20]

	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import cpvpi_pkg::*;

	logic               busy;
	pc_t                pc;
	ucw_t               cw;
	dp_ctl_t            ctl;
	dp_stat_t           stat;
	logic               in_accept;
	logic signed [15:0] motor_command;
	logic               in_band, setpoint_at_goal, at_floor, at_top;

	// Single item in flight; the result register decouples the output side,
	// so the next beat is taken while a finished result still waits.
	assign s_axis_tready = !busy;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Writes always land at once; the user must issue them only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	// control store
	cpvpi_ucode_rom u_rom (
		.pc (pc),
		.cw (cw)
	);

	// step counter and branch logic
	cpvpi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.cw     (cw),
		.stat   (stat),
		.busy   (busy),
		.pc     (pc),
		.ctl    (ctl)
	);

	// datapath: state, MAC, clamps, result register
	cpvpi_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (in_accept),
		.operation         (s_axis_tuser),
		.measured_position ($signed(s_axis_tdata[31:0])),
		.goal_height       ($signed(s_axis_tdata[63:32])),
		.jog_command       ($signed(s_axis_tdata[79:64])),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.ctl               (ctl),
		.out_ready         (m_axis_tready),
		.stat              (stat),
		.out_valid         (m_axis_tvalid),
		.motor_command     (motor_command),
		.in_band           (in_band),
		.setpoint_at_goal  (setpoint_at_goal),
		.at_floor          (at_floor),
		.at_top            (at_top)
	);

	assign m_axis_tdata = {4'b0000, at_top, at_floor, setpoint_at_goal, in_band,
		motor_command};

	// every accepted beat starts the program at the dispatch step
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (busy && pc == PC_DISPATCH))
		else $error("program did not start at dispatch");

	// the step counter never leaves the program
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (pc <= PC_OUT))
		else $error("step counter out of program range");

	// a result only appears as the end of a running program
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(busy) && $past(pc) == PC_OUT))
		else $error("result valid without program end");

	// drive stays inside the motor limit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (motor_command <= MOTOR_LIMIT && motor_command >= -MOTOR_LIMIT))
		else $error("motor command beyond limit");

endmodule

[rtl/core/cpvpi_ucode_rom.sv]
// ----------------------------------------------------------------------------
// cpvpi_ucode_rom
// Control store: one control word per program step.
// ----------------------------------------------------------------------------
module cpvpi_ucode_rom (
	input  cpvpi_pkg::pc_t  pc,
	output cpvpi_pkg::ucw_t cw
);
	import cpvpi_pkg::*;

	function automatic ucw_t mk(uop_t u, gain_t g, logic ld, cond_t c, pc_t t, logic w,
			logic d);
		ucw_t r;
		r.uop      = u;
		r.gain     = g;
		r.ld_dsp   = ld;
		r.cond     = c;
		r.target   = t;
		r.wait_out = w;
		r.done     = d;
		return r;
	endfunction

	always_comb begin
		unique case (pc)
			PC_DISPATCH: cw = mk(UOP_NOP, GAIN_POS, 1'b0, COND_NOT_TICK, PC_MISC, 1'b0, 1'b0);
			PC_CLAMP:    cw = mk(UOP_CLAMP_GOAL, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_DIFF:     cw = mk(UOP_DIFF, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_MOVE:     cw = mk(UOP_MOVE_SP, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			// inside the band the P/FF products are not needed
			PC_BAND:     cw = mk(UOP_BAND, GAIN_POS, 1'b0, COND_BAND, PC_VERR, 1'b0, 1'b0);
			PC_PG_LO:    cw = mk(UOP_MAC_LO, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_PG_HI:    cw = mk(UOP_MAC_HI, GAIN_POS, 1'b1, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_FF_LO:    cw = mk(UOP_MAC_LO, GAIN_FF, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_FF_HI:    cw = mk(UOP_MAC_HI, GAIN_FF, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_VERR:     cw = mk(UOP_VERR, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_INTEG:    cw = mk(UOP_INTEG, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_LD_LO:    cw = mk(UOP_MAC_LO, GAIN_LEAD, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_LD_HI:    cw = mk(UOP_MAC_HI, GAIN_LEAD, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_TSUM:     cw = mk(UOP_TSUM, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_IN_LO:    cw = mk(UOP_MAC_LO, GAIN_INNER, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_IN_HI:    cw = mk(UOP_MAC_HI, GAIN_INNER, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_DRIVE:    cw = mk(UOP_DRIVE, GAIN_POS, 1'b0, COND_ALWAYS, PC_OUT, 1'b0, 1'b0);
			PC_MISC:     cw = mk(UOP_MISC, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b0);
			PC_OUT:      cw = mk(UOP_OUT, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b1, 1'b1);
			default:     cw = mk(UOP_NOP, GAIN_POS, 1'b0, COND_NONE, PC_DISPATCH, 1'b0, 1'b1);
		endcase
	end

endmodule

[rtl/core/cpvpi_seq.sv]
// ----------------------------------------------------------------------------
// cpvpi_seq
// Step counter with conditional jumps; issues control words to the datapath.
// ----------------------------------------------------------------------------
module cpvpi_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cpvpi_pkg::ucw_t    cw,
	input  cpvpi_pkg::dp_stat_t stat,
	output logic               busy,
	output cpvpi_pkg::pc_t     pc,
	output cpvpi_pkg::dp_ctl_t ctl
);
	import cpvpi_pkg::*;

	logic busy_q;
	pc_t  pc_q;
	logic stall;
	logic jump;

	assign stall = cw.wait_out && !stat.out_free;

	always_comb begin
		unique case (cw.cond)
			COND_NONE:     jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_NOT_TICK: jump = !stat.is_tick;
			COND_BAND:     jump = stat.band_hit;
			default:       jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_DISPATCH;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= PC_DISPATCH;
		end else if (busy_q && !stall) begin
			if (cw.done) begin
				busy_q <= 1'b0;
			end else if (jump) begin
				pc_q <= cw.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	assign busy       = busy_q;
	assign pc         = pc_q;
	assign ctl.fire   = busy_q && !stall;
	assign ctl.uop    = cw.uop;
	assign ctl.gain   = cw.gain;
	assign ctl.ld_dsp = cw.ld_dsp;

endmodule

[rtl/core/cpvpi_dp.sv]
// ----------------------------------------------------------------------------
// cpvpi_dp
// Datapath: loop state, config registers, shared 17x25 multiply-accumulate,
// compare/clamp unit and the result register.
// ----------------------------------------------------------------------------
module cpvpi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [2:0]          operation,
	input  logic signed [31:0]  measured_position,
	input  logic signed [31:0]  goal_height,
	input  logic signed [15:0]  jog_command,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  cpvpi_pkg::dp_ctl_t  ctl,
	input  logic                out_ready,
	output cpvpi_pkg::dp_stat_t stat,
	output logic                out_valid,
	output logic signed [15:0]  motor_command,
	output logic                in_band,
	output logic                setpoint_at_goal,
	output logic                at_floor,
	output logic                at_top
);
	import cpvpi_pkg::*;

	function automatic logic signed [32:0] sx33(logic signed [31:0] v);
		return $signed({v[31], v});
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [31:0] v,
			logic signed [31:0] lo, logic signed [31:0] hi);
		logic signed [31:0] c;
		c = v;
		if (c < lo) c = lo;
		if (c > hi) c = hi;
		return c;
	endfunction

	// config
	logic [15:0]        pos_gain_q, ff_gain_q, inner_gain_q, lead_ticks_q;
	logic signed [31:0] bottom_q, top_q;
	logic [30:0]        max_step_q, settle_q;

	// loop state
	logic signed [31:0] goal_q, sp_q, psp_q, ppos_q, vint_q;
	logic signed [15:0] drive_q;
	logic               band_q, jogging_q;

	// item and scratch
	logic [2:0]         op_q;
	logic signed [31:0] pos_q, gh_q;
	logic signed [15:0] jog_q;
	logic signed [32:0] a_q, v_q;
	logic signed [43:0] e_q;
	logic signed [47:0] x_q;
	logic signed [63:0] acc_q;

	// result register
	logic               out_valid_q;
	logic signed [15:0] motor_q;
	logic               in_band_q, sag_q, floor_q, top_hit_q;

	// combinational
	logic signed [32:0] gsp_d, vel_d, gpos_d, perr_d, dsp_d, ms_s, sb_s, step_d;
	logic signed [31:0] goal_clamped, gh_clamped;
	logic               band_now, sag_now, out_free;
	logic [15:0]        gain_sel;
	logic signed [24:0] chunk;
	logic signed [41:0] prod;
	logic signed [63:0] term, acc_sh, m_d;
	logic signed [43:0] vcmd_d, e_next, e_clamped, acc_lo44;
	logic signed [44:0] isum, ilim;
	logic signed [31:0] vint_next;
	logic signed [50:0] tsum, acc_lo51;
	logic signed [47:0] t_clamped;
	logic signed [15:0] drive_next;
	logic signed [16:0] jog_x;
	logic               jog_up, jog_dead, jog_block;
	logic signed [32:0] jog_sum;
	logic signed [31:0] jog_goal;

	assign gsp_d  = sx33(goal_q) - sx33(sp_q);
	assign vel_d  = sx33(pos_q) - sx33(ppos_q);
	assign gpos_d = sx33(goal_q) - sx33(pos_q);
	assign perr_d = sx33(sp_q) - sx33(pos_q);
	assign dsp_d  = sx33(sp_q) - sx33(psp_q);
	assign ms_s   = $signed({2'b00, max_step_q});
	assign sb_s   = $signed({2'b00, settle_q});

	assign goal_clamped = clamp32(goal_q, bottom_q, top_q);
	assign gh_clamped   = clamp32(gh_q, bottom_q, top_q);

	assign band_now = (gpos_d <= sb_s) && (gpos_d >= -sb_s);
	assign sag_now  = (gsp_d <= GOAL_ALLOWANCE) && (gsp_d >= -GOAL_ALLOWANCE);
	assign out_free = !out_valid_q || out_ready;

	// setpoint step limit
	always_comb begin
		if (a_q > ms_s) begin
			step_d = ms_s;
		end else if (a_q < -ms_s) begin
			step_d = -ms_s;
		end else begin
			step_d = a_q;
		end
	end

	// shared multiplier: unsigned gain times one 24-bit chunk of the operand
	always_comb begin
		unique case (ctl.gain)
			GAIN_POS:   gain_sel = pos_gain_q;
			GAIN_FF:    gain_sel = ff_gain_q;
			GAIN_INNER: gain_sel = inner_gain_q;
			GAIN_LEAD:  gain_sel = lead_ticks_q;
			default:    gain_sel = pos_gain_q;
		endcase
		if (ctl.uop == UOP_MAC_HI) begin
			chunk = $signed({x_q[47], x_q[47:24]});
		end else begin
			chunk = $signed({1'b0, x_q[23:0]});
		end
		prod = $signed({1'b0, gain_sel}) * chunk;
		term = $signed({{22{prod[41]}}, prod});
		if (ctl.uop == UOP_MAC_HI) begin
			term = term <<< 24;
		end
	end

	assign acc_sh   = acc_q >>> 8;
	assign acc_lo44 = acc_sh[43:0];
	assign acc_lo51 = acc_sh[50:0];

	// velocity error and integrator
	always_comb begin
		vcmd_d = band_q ? 44'sd0 : acc_lo44;
		e_next = vcmd_d - $signed({{11{v_q[32]}}, v_q});

		isum = $signed({e_q[43], e_q}) + $signed({{13{vint_q[31]}}, vint_q});
		ilim = $signed({{13{INT_LIMIT[31]}}, INT_LIMIT});
		if (isum > ilim) begin
			vint_next = INT_LIMIT;
		end else if (isum < -ilim) begin
			vint_next = -INT_LIMIT;
		end else begin
			vint_next = isum[31:0];
		end

		if (e_q > VERR_LIM) begin
			e_clamped = VERR_LIM;
		end else if (e_q < -VERR_LIM) begin
			e_clamped = -VERR_LIM;
		end else begin
			e_clamped = e_q;
		end

		tsum = acc_lo51 + $signed({{19{vint_q[31]}}, vint_q});
		if (tsum > TSUM_LIM) begin
			t_clamped = TSUM_LIM[47:0];
		end else if (tsum < -TSUM_LIM) begin
			t_clamped = -TSUM_LIM[47:0];
		end else begin
			t_clamped = tsum[47:0];
		end

		m_d = (acc_sh >>> FRAC_SHR) <<< FRAC_SHL;
		if (m_d > $signed({{48{1'b0}}, MOTOR_LIMIT})) begin
			drive_next = MOTOR_LIMIT;
		end else if (m_d < -$signed({{48{1'b0}}, MOTOR_LIMIT})) begin
			drive_next = -MOTOR_LIMIT;
		end else begin
			drive_next = m_d[15:0];
		end
	end

	// manual jog
	always_comb begin
		jog_x     = $signed({jog_q[15], jog_q});
		jog_up    = jog_q > 16'sd0;
		jog_dead  = (jog_x < JOG_DEADBAND) && (jog_x > -JOG_DEADBAND);
		jog_block = jog_up ? (pos_q >= top_q) : (pos_q <= bottom_q);
		jog_sum   = jog_up ? sx33(goal_q) + sx33(JOG_STEP) : sx33(goal_q) - sx33(JOG_STEP);
		if (jog_sum[32] != jog_sum[31]) begin
			jog_goal = jog_sum[32] ? $signed({1'b1, 31'd0}) : $signed({1'b0, {31{1'b1}}});
		end else begin
			jog_goal = jog_sum[31:0];
		end
	end

	// config and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_gain_q   <= 16'd256;
			ff_gain_q    <= 16'd256;
			inner_gain_q <= 16'd256;
			lead_ticks_q <= 16'd256;
			bottom_q     <= 32'sd0;
			top_q        <= 32'sd4194304;
			max_step_q   <= 31'd65536;
			settle_q     <= 31'd32768;
			goal_q       <= '0;
			sp_q         <= '0;
			psp_q        <= '0;
			ppos_q       <= '0;
			vint_q       <= '0;
			drive_q      <= '0;
			band_q       <= 1'b0;
			jogging_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_POS_GAIN:     pos_gain_q   <= cfg_data[15:0];
					REG_FF_GAIN:      ff_gain_q    <= cfg_data[15:0];
					REG_INNER_GAIN:   inner_gain_q <= cfg_data[15:0];
					REG_LEAD_TICKS:   lead_ticks_q <= cfg_data[15:0];
					REG_BOTTOM_LIMIT: bottom_q     <= $signed(cfg_data);
					REG_TOP_LIMIT:    top_q        <= $signed(cfg_data);
					REG_MAX_STEP:     max_step_q   <= cfg_data[30:0];
					REG_SETTLE_BAND:  settle_q     <= cfg_data[30:0];
					default:          ;
				endcase
			end

			if (ctl.fire && ctl.uop == UOP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (ctl.fire) begin
				unique case (ctl.uop)
					UOP_CLAMP_GOAL: goal_q <= goal_clamped;
					UOP_MOVE_SP:    sp_q   <= sp_q + step_d[31:0];
					UOP_BAND:       band_q <= band_now;
					UOP_INTEG:      vint_q <= vint_next;
					UOP_DRIVE: begin
						drive_q <= drive_next;
						ppos_q  <= pos_q;
						psp_q   <= sp_q;
					end
					UOP_MISC: begin
						unique case (op_q)
							OP_SET_GOAL: begin
								jogging_q <= 1'b0;
								goal_q    <= gh_clamped;
							end
							OP_JOG: begin
								if (!jog_dead && !jog_block) begin
									jogging_q <= 1'b1;
									goal_q    <= jogging_q ? jog_goal : pos_q;
								end
							end
							OP_STOP: begin
								goal_q <= pos_q;
								sp_q   <= pos_q;
								psp_q  <= pos_q;
								ppos_q <= pos_q;
							end
							OP_RESET: begin
								goal_q    <= pos_q;
								sp_q      <= pos_q;
								psp_q     <= pos_q;
								ppos_q    <= pos_q;
								vint_q    <= '0;
								drive_q   <= '0;
								jogging_q <= 1'b0;
								band_q    <= 1'b0;
							end
							default: ;
						endcase
					end
					default: ;
				endcase
			end
		end
	end

	// item registers, scratch and result payload
	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= operation;
			pos_q <= measured_position;
			gh_q  <= goal_height;
			jog_q <= jog_command;
		end
		if (ctl.fire) begin
			unique case (ctl.uop)
				UOP_DIFF: begin
					a_q <= gsp_d;
					v_q <= vel_d;
				end
				UOP_BAND: begin
					x_q   <= $signed({{15{perr_d[32]}}, perr_d});
					acc_q <= '0;
				end
				UOP_MAC_LO: acc_q <= acc_q + term;
				UOP_MAC_HI: begin
					acc_q <= acc_q + term;
					if (ctl.ld_dsp) begin
						x_q <= $signed({{15{dsp_d[32]}}, dsp_d});
					end
				end
				UOP_VERR: e_q <= e_next;
				UOP_INTEG: begin
					x_q   <= $signed({{4{e_clamped[43]}}, e_clamped});
					acc_q <= '0;
				end
				UOP_TSUM: begin
					x_q   <= t_clamped;
					acc_q <= '0;
				end
				UOP_OUT: begin
					motor_q   <= drive_q;
					in_band_q <= band_q;
					sag_q     <= sag_now;
					floor_q   <= pos_q <= bottom_q;
					top_hit_q <= pos_q >= top_q;
				end
				default: ;
			endcase
		end
	end

	assign stat.is_tick  = op_q == OP_TICK;
	assign stat.band_hit = band_now;
	assign stat.out_free = out_free;

	assign out_valid        = out_valid_q;
	assign motor_command    = motor_q;
	assign in_band          = in_band_q;
	assign setpoint_at_goal = sag_q;
	assign at_floor         = floor_q;
	assign at_top           = top_hit_q;

endmodule
